// File: rtl/kpib_pkg.sv
// ----------------------------------------------------------------------------
// kpib_pkg
// Shared widths, codes and controller/datapath handshake types for the
// k-mer position index builder.
// ----------------------------------------------------------------------------
package kpib_pkg;

    // default sizes handed to the top level
    localparam int MAX_KMER_DEF = 6;
    localparam int BUCKETS_DEF  = 4096;
    localparam int SLOTS_DEF    = 8;
    localparam int POS_BITS_DEF = 16;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int BASE_W     = 2;
    localparam int CODE_W     = 12;
    localparam int SLOT_W     = 3;
    localparam int CNT_OUT_W  = 4;
    localparam int POS_OUT_W  = 16;
    localparam int KLEN_W     = 3;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    localparam logic [KLEN_W-1:0]  KLEN_RST  = 3'd6;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMER_LENGTH  = 4'd0,
        REG_BUCKET_LIMIT = 4'd1
    } t_reg_idx;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch request, advance roller, launch lookups
        logic finish;     // complete lookup, update memories, load result
        logic emit_zero;  // load an all-zero result
        logic clr_step;   // zero one count entry, advance sweep
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;   // latched request is a clear
        logic out_free;   // result register can take a new result
        logic clr_last;   // sweep is at the last bucket
    } t_dp_status;

endpackage

// File: rtl/kpib_if.sv
// ----------------------------------------------------------------------------
// kpib interfaces
// Request, result and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface kpib_in_if import kpib_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [BASE_W-1:0]   base;
    logic                first_of_read;
    logic [CODE_W-1:0]   query_kmer;
    logic [SLOT_W-1:0]   query_slot;

    modport source (output valid, command, base, first_of_read, query_kmer, query_slot,
                    input ready);
    modport sink   (input valid, command, base, first_of_read, query_kmer, query_slot,
                    output ready);
endinterface

interface kpib_out_if import kpib_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 inserted;
    logic                 bucket_full;
    logic                 too_long;
    logic [CODE_W-1:0]    kmer_code;
    logic [CNT_OUT_W-1:0] bucket_count;
    logic [POS_OUT_W-1:0] position;

    modport source (output valid, inserted, bucket_full, too_long, kmer_code,
                    bucket_count, position, input ready);
    modport sink   (input valid, inserted, bucket_full, too_long, kmer_code,
                    bucket_count, position, output ready);
endinterface

interface kpib_cfg_if import kpib_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/kpib_ram.sv
// ----------------------------------------------------------------------------
// kpib_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kpib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kpib_ctrl.sv
// ----------------------------------------------------------------------------
// kpib_ctrl
// Sequencer: count-memory sweep, request accept, lookup completion, result.
// ----------------------------------------------------------------------------
module kpib_ctrl import kpib_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_zero = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/kpib_dp.sv
// ----------------------------------------------------------------------------
// kpib_dp
// Datapath: config registers, k-mer roller, base counter, count and
// position memories, result register.
// ----------------------------------------------------------------------------
module kpib_dp import kpib_pkg::*; #(
    parameter int MAX_KMER = MAX_KMER_DEF,
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int SLOTS    = SLOTS_DEF,
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BASE_W-1:0] i_base,
    input  logic              i_first_of_read,
    input  logic [CODE_W-1:0] i_query_kmer,
    input  logic [SLOT_W-1:0] i_query_slot,
    kpib_out_if.source        o_out,
    kpib_cfg_if.sink          i_cfg
);

    localparam int ROLL_W = 2 * MAX_KMER;
    localparam int K_W    = $clog2(MAX_KMER + 1);
    localparam int CNTR_W = POS_BITS + 1;
    localparam int CA_W   = $clog2(BUCKETS);
    localparam int PDEPTH = BUCKETS * SLOTS;
    localparam int PA_W   = $clog2(PDEPTH);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // config
    logic [KLEN_W-1:0]  r_klen;
    logic [LIMIT_W-1:0] r_limit;

    // sequence state
    logic [ROLL_W-1:0]  r_roll;
    logic [CNTR_W-1:0]  r_cnt;

    // latched request
    t_cmd               r_cmd;
    logic [CODE_W-1:0]  r_qk;
    logic [SLOT_W-1:0]  r_qs;
    logic               r_qk_ok;
    logic               r_slot_ok;
    logic               r_toolong;
    logic               r_complete;
    logic [POS_BITS-1:0] r_start;
    logic [CA_W-1:0]    r_caddr;

    // clear sweep
    logic [CA_W-1:0]    r_clr;

    // result register
    logic                 r_o_valid;
    logic                 r_o_ins;
    logic                 r_o_full;
    logic                 r_o_tl;
    logic [CODE_W-1:0]    r_o_code;
    logic [CNT_OUT_W-1:0] r_o_cnt;
    logic [POS_OUT_W-1:0] r_o_pos;

    logic                 n_o_ins;
    logic                 n_o_full;
    logic [CNT_OUT_W-1:0] n_o_cnt;
    logic [POS_OUT_W-1:0] n_o_pos;
    logic [CODE_W-1:0]    n_o_code;

    logic [K_W-1:0]      eff_k;
    logic [ROLL_W-1:0]   mask;
    logic [ROLL_W-1:0]   n_roll;
    logic [CNTR_W-1:0]   j;
    logic                j_toolong;
    logic [POS_BITS-1:0] start;
    logic                is_push;

    logic [CNT_W-1:0]    cnt_rd;
    logic [POS_BITS-1:0] pos_rd;
    logic                can_ins;
    logic                do_ins;
    logic                cnt_we;
    logic [CA_W-1:0]     cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CA_W-1:0]     cnt_raddr;
    logic [PA_W-1:0]     pos_raddr;
    logic [PA_W-1:0]     pos_waddr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen  <= KLEN_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_KMER_LENGTH) begin
                r_klen <= i_cfg.data[KLEN_W-1:0];
            end
            if (i_cfg.index == REG_BUCKET_LIMIT) begin
                r_limit <= i_cfg.data[LIMIT_W-1:0];
            end
        end
    end

    // k clamped to 1..MAX_KMER
    always_comb begin
        if (r_klen == '0) begin
            eff_k = K_W'(1);
        end else if (32'(r_klen) > MAX_KMER) begin
            eff_k = K_W'(MAX_KMER);
        end else begin
            eff_k = K_W'(r_klen);
        end
    end

    always_comb begin
        for (int i = 0; i < ROLL_W; i++) begin
            mask[i] = (i < 2 * int'(eff_k));
        end
    end

    assign is_push   = (t_cmd'(i_command) == CMD_PUSH);
    assign n_roll    = ROLL_W'({(i_first_of_read ? '0 : r_roll), i_base}) & mask;
    assign j         = i_first_of_read ? '0 : r_cnt;
    assign j_toolong = j[POS_BITS];
    assign start     = POS_BITS'(j) + POS_BITS'(1) - POS_BITS'(eff_k);

    // lookup addresses launched at accept
    assign cnt_raddr = is_push ? CA_W'(n_roll) : CA_W'(i_query_kmer);
    assign pos_raddr = PA_W'(PA_W'(CA_W'(i_query_kmer)) * PA_W'(SLOTS)
                             + PA_W'(i_query_slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.accept && is_push) begin
            r_roll <= n_roll;
            r_cnt  <= j_toolong ? j : j + CNTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= t_cmd'(i_command);
            r_qk       <= i_query_kmer;
            r_qs       <= i_query_slot;
            r_qk_ok    <= (32'(i_query_kmer) < BUCKETS);
            r_slot_ok  <= (32'(i_query_slot) < SLOTS);
            r_toolong  <= j_toolong;
            r_complete <= !j_toolong && (j >= CNTR_W'(eff_k - K_W'(1)))
                          && (32'(n_roll) < BUCKETS);
            r_start    <= start;
            r_caddr    <= CA_W'(n_roll);
        end
    end

    // sweep counter wraps so each clear starts at bucket zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= o_status.clr_last ? '0 : r_clr + CA_W'(1);
        end
    end

    assign can_ins   = (32'(cnt_rd) < 32'(r_limit)) && (32'(cnt_rd) < SLOTS);
    assign do_ins    = i_cmd.finish && (r_cmd == CMD_PUSH) && r_complete && can_ins;
    assign cnt_we    = i_cmd.clr_step || do_ins;
    assign cnt_waddr = i_cmd.clr_step ? r_clr : r_caddr;
    assign cnt_wdata = i_cmd.clr_step ? '0 : cnt_rd + CNT_W'(1);
    assign pos_waddr = PA_W'(PA_W'(r_caddr) * PA_W'(SLOTS) + PA_W'(cnt_rd));

    kpib_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rd)
    );

    kpib_ram #(.WIDTH(POS_BITS), .DEPTH(PDEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (do_ins),
        .i_waddr (pos_waddr),
        .i_wdata (r_start),
        .i_re    (i_cmd.accept),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rd)
    );

    // result of a finished lookup
    always_comb begin
        n_o_ins  = 1'b0;
        n_o_full = 1'b0;
        n_o_cnt  = '0;
        n_o_pos  = '0;
        n_o_code = '0;
        unique case (r_cmd)
            CMD_PUSH: begin
                n_o_code = CODE_W'(r_roll);
                if (r_complete) begin
                    if (can_ins) begin
                        n_o_ins = 1'b1;
                        n_o_cnt = CNT_OUT_W'(cnt_rd + CNT_W'(1));
                        n_o_pos = POS_OUT_W'(r_start);
                    end else begin
                        n_o_full = 1'b1;
                        n_o_cnt  = CNT_OUT_W'(cnt_rd);
                    end
                end
            end
            CMD_READ: begin
                n_o_code = r_qk;
                if (r_qk_ok) begin
                    n_o_cnt = CNT_OUT_W'(cnt_rd);
                    if (r_slot_ok && (32'(r_qs) < 32'(cnt_rd))) begin
                        n_o_pos = POS_OUT_W'(pos_rd);
                    end
                end
            end
            default: begin
                n_o_code = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish || i_cmd.emit_zero) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_ins  <= n_o_ins;
            r_o_full <= n_o_full;
            r_o_tl   <= (r_cmd == CMD_PUSH) && r_toolong;
            r_o_code <= n_o_code;
            r_o_cnt  <= n_o_cnt;
            r_o_pos  <= n_o_pos;
        end else if (i_cmd.emit_zero) begin
            r_o_ins  <= 1'b0;
            r_o_full <= 1'b0;
            r_o_tl   <= 1'b0;
            r_o_code <= '0;
            r_o_cnt  <= '0;
            r_o_pos  <= '0;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.inserted     = r_o_ins;
    assign o_out.bucket_full  = r_o_full;
    assign o_out.too_long     = r_o_tl;
    assign o_out.kmer_code    = r_o_code;
    assign o_out.bucket_count = r_o_cnt;
    assign o_out.position     = r_o_pos;

    assign o_status.is_clear = (r_cmd == CMD_CLEAR);
    assign o_status.out_free = !r_o_valid || o_out.ready;
    assign o_status.clr_last = (r_clr == CA_W'(BUCKETS - 1));

endmodule

// File: rtl/kmer_position_index_builder.sv
// ----------------------------------------------------------------------------
// kmer_position_index_builder
// Direct-addressed k-mer position index, one base per push request.
// ----------------------------------------------------------------------------
// Push, read and no-op requests: result registered on leaving S_LOOK after
//   accept, next request accepted only after that result is registered (count
//   memory read, then count/position write on the same bucket).
// Clear request: S_CLEAR zeroes one count entry per cycle over all BUCKETS
//   entries, then S_EMIT registers an all-zero result before the next request.
// A result held by the sink stalls the finish of the next request.
// Reset: synchronous, active low; then a pass over all BUCKETS entries zeroes
//   the count memory, request channel held off (config writes still taken).
// ----------------------------------------------------------------------------
module kmer_position_index_builder import kpib_pkg::*; #(
    parameter int MAX_KMER = MAX_KMER_DEF,
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int SLOTS    = SLOTS_DEF,
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpib_in_if.sink     i_in,
    kpib_out_if.source  o_out,
    kpib_cfg_if.sink    i_cfg
);

    // controller/datapath handshake
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    // Sequencer: sweep after reset, accept, finish lookup or run a clear.
    kpib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (dp_status),
        .o_in_ready (in_ready),
        .o_cmd      (ctrl_cmd)
    );

    // Roller, counter, count and position memories, result register.
    kpib_dp #(
        .MAX_KMER (MAX_KMER),
        .BUCKETS  (BUCKETS),
        .SLOTS    (SLOTS),
        .POS_BITS (POS_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_status        (dp_status),
        .i_command       (i_in.command),
        .i_base          (i_in.base),
        .i_first_of_read (i_in.first_of_read),
        .i_query_kmer    (i_in.query_kmer),
        .i_query_slot    (i_in.query_slot),
        .o_out           (o_out),
        .i_cfg           (i_cfg)
    );

endmodule
